@@ rtl/axis_rotation_3d_top_macros.svh @@
// assertion macros for the vertex rotation block
`ifndef AXIS_ROTATION_3D_TOP_MACROS_SVH
`define AXIS_ROTATION_3D_TOP_MACROS_SVH
`ifndef SYNTH
`define ROT3D_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rot3d check failed");
`define ROT3D_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("rot3d check failed");
`else
`define ROT3D_ASSERT(label, prop)
`define ROT3D_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ rtl/rot3d_pkg.sv @@
`default_nettype none
package rot3d_pkg;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      axis_type func;
      quad_type quad;
   } meta_type;

   localparam int ANGLE_FULL_W = 32;
   localparam int CORDIC_W     = 34;
   localparam int RESID_W      = 33;
   localparam int CORDIC_FRAC  = 30;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;
   localparam logic [ANGLE_FULL_W-1:0] EIGHTH_TURN = 32'h2000_0000;

   // arctangent of 2^-idx, 2^32 per turn
   function automatic logic [31:0] atan_value(input int idx);
      logic [31:0] v;
      case (idx)
         0:       v = 32'h20000000;
         1:       v = 32'h12E4051E;
         2:       v = 32'h09FB385B;
         3:       v = 32'h051111D4;
         4:       v = 32'h028B0D43;
         5:       v = 32'h0145D7E1;
         6:       v = 32'h00A2F61E;
         7:       v = 32'h00517C55;
         8:       v = 32'h0028BE53;
         9:       v = 32'h00145F2F;
         10:      v = 32'h000A2F98;
         11:      v = 32'h000517CC;
         12:      v = 32'h00028BE6;
         13:      v = 32'h000145F3;
         14:      v = 32'h0000A2FA;
         15:      v = 32'h0000517D;
         16:      v = 32'h000028BE;
         17:      v = 32'h0000145F;
         18:      v = 32'h00000A30;
         19:      v = 32'h00000518;
         20:      v = 32'h0000028C;
         21:      v = 32'h00000146;
         22:      v = 32'h000000A3;
         23:      v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ rtl/rot3d_cordic_cell.sv @@
`default_nettype none
module rot3d_cordic_cell #(
   parameter int COORD_WIDTH = 32,
   parameter int SHIFT       = 0
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  rot3d_pkg::meta_type                        in_meta,
   input  logic [3*COORD_WIDTH-1:0]                   in_vertex,
   input  logic signed [rot3d_pkg::CORDIC_W-1:0]      in_cx,
   input  logic signed [rot3d_pkg::CORDIC_W-1:0]      in_cy,
   input  logic signed [rot3d_pkg::RESID_W-1:0]       in_cz,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output rot3d_pkg::meta_type                        out_meta,
   output logic [3*COORD_WIDTH-1:0]                   out_vertex,
   output logic signed [rot3d_pkg::CORDIC_W-1:0]      out_cx,
   output logic signed [rot3d_pkg::CORDIC_W-1:0]      out_cy,
   output logic signed [rot3d_pkg::RESID_W-1:0]       out_cz
);
   import rot3d_pkg::*;

   logic                       valid_ff;
   meta_type                   meta_ff;
   logic [3*COORD_WIDTH-1:0]   vertex_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [RESID_W-1:0]  cz_ff, cz_in;
   logic signed [RESID_W-1:0]  atan_step;

   assign atan_step = $signed({1'b0, atan_value(SHIFT)});

   always_comb begin
      if (!in_cz[RESID_W-1]) begin
         cx_in = in_cx - (in_cy >>> SHIFT);
         cy_in = in_cy + (in_cx >>> SHIFT);
         cz_in = in_cz - atan_step;
      end else begin
         cx_in = in_cx + (in_cy >>> SHIFT);
         cy_in = in_cy - (in_cx >>> SHIFT);
         cz_in = in_cz + atan_step;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         meta_ff   <= in_meta;
         vertex_ff <= in_vertex;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         cz_ff     <= cz_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_meta   = meta_ff;
   assign out_vertex = vertex_ff;
   assign out_cx     = cx_ff;
   assign out_cy     = cy_ff;
   assign out_cz     = cz_ff;

endmodule
`default_nettype wire

@@ rtl/rot3d_trig_map.sv @@
`default_nettype none
module rot3d_trig_map #(
   parameter int COORD_WIDTH = 32,
   parameter int TRIG_FRAC   = 30,
   parameter int TRIG_W      = 34
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  rot3d_pkg::meta_type                     in_meta,
   input  logic [3*COORD_WIDTH-1:0]                in_vertex,
   input  logic signed [rot3d_pkg::CORDIC_W-1:0]   in_cx,
   input  logic signed [rot3d_pkg::CORDIC_W-1:0]   in_cy,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output rot3d_pkg::axis_type                     out_func,
   output logic [3*COORD_WIDTH-1:0]                out_vertex,
   output logic signed [COORD_WIDTH-1:0]           out_a,
   output logic signed [COORD_WIDTH-1:0]           out_b,
   output logic signed [TRIG_W-1:0]                out_c,
   output logic signed [TRIG_W-1:0]                out_s
);
   import rot3d_pkg::*;

   localparam int SHIFT_R = CORDIC_FRAC - TRIG_FRAC;

   logic                          valid_ff;
   axis_type                      func_ff;
   logic [3*COORD_WIDTH-1:0]      vertex_ff;
   logic signed [COORD_WIDTH-1:0] a_ff, b_ff, a_in, b_in;
   logic signed [TRIG_W-1:0]      c_ff, s_ff, c_in, s_in;
   logic signed [CORDIC_W-1:0]    cm, sm;
   logic signed [COORD_WIDTH-1:0] vx, vy, vz;

   assign vx = in_vertex[COORD_WIDTH-1:0];
   assign vy = in_vertex[2*COORD_WIDTH-1:COORD_WIDTH];
   assign vz = in_vertex[3*COORD_WIDTH-1:2*COORD_WIDTH];

   always_comb begin
      case (in_meta.quad)
         QUAD_0: begin
            cm = in_cx;
            sm = in_cy;
         end
         QUAD_1: begin
            cm = -in_cy;
            sm = in_cx;
         end
         QUAD_2: begin
            cm = -in_cx;
            sm = -in_cy;
         end
         default: begin
            cm = in_cy;
            sm = -in_cx;
         end
      endcase
   end

   generate
      if (SHIFT_R == 0) begin : g_keep
         assign c_in = TRIG_W'(cm);
         assign s_in = TRIG_W'(sm);
      end else begin : g_round
         logic signed [CORDIC_W-1:0] ct, st;
         assign ct   = (cm >>> (SHIFT_R - 1)) + 1;
         assign st   = (sm >>> (SHIFT_R - 1)) + 1;
         assign c_in = TRIG_W'(ct >>> 1);
         assign s_in = TRIG_W'(st >>> 1);
      end
   endgenerate

   // operand pair (a, b) rotated into (a*c - b*s, a*s + b*c)
   always_comb begin
      case (in_meta.func)
         AXIS_X: begin
            a_in = vy;
            b_in = vz;
         end
         AXIS_Y: begin
            a_in = vz;
            b_in = vx;
         end
         default: begin
            a_in = vx;
            b_in = vy;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         func_ff   <= in_meta.func;
         vertex_ff <= in_vertex;
         a_ff      <= a_in;
         b_ff      <= b_in;
         c_ff      <= c_in;
         s_ff      <= s_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_func   = func_ff;
   assign out_vertex = vertex_ff;
   assign out_a      = a_ff;
   assign out_b      = b_ff;
   assign out_c      = c_ff;
   assign out_s      = s_ff;

endmodule
`default_nettype wire

@@ rtl/rot3d_mult.sv @@
`default_nettype none
module rot3d_mult #(
   parameter int COORD_WIDTH = 32,
   parameter int TRIG_W      = 34,
   parameter int PROD_W      = 66
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  rot3d_pkg::axis_type              in_func,
   input  logic [3*COORD_WIDTH-1:0]         in_vertex,
   input  logic signed [COORD_WIDTH-1:0]    in_a,
   input  logic signed [COORD_WIDTH-1:0]    in_b,
   input  logic signed [TRIG_W-1:0]         in_c,
   input  logic signed [TRIG_W-1:0]         in_s,
   output logic                             out_valid,
   input  logic                             out_ready,
   output rot3d_pkg::axis_type              out_func,
   output logic [3*COORD_WIDTH-1:0]         out_vertex,
   output logic signed [PROD_W-1:0]         out_ac,
   output logic signed [PROD_W-1:0]         out_bs,
   output logic signed [PROD_W-1:0]         out_as,
   output logic signed [PROD_W-1:0]         out_bc
);
   import rot3d_pkg::*;

   logic                     valid_ff;
   axis_type                 func_ff;
   logic [3*COORD_WIDTH-1:0] vertex_ff;
   logic signed [PROD_W-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [PROD_W-1:0] ac_in, bs_in, as_in, bc_in;

   assign ac_in = in_a * in_c;
   assign bs_in = in_b * in_s;
   assign as_in = in_a * in_s;
   assign bc_in = in_b * in_c;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         func_ff   <= in_func;
         vertex_ff <= in_vertex;
         ac_ff     <= ac_in;
         bs_ff     <= bs_in;
         as_ff     <= as_in;
         bc_ff     <= bc_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_func   = func_ff;
   assign out_vertex = vertex_ff;
   assign out_ac     = ac_ff;
   assign out_bs     = bs_ff;
   assign out_as     = as_ff;
   assign out_bc     = bc_ff;

endmodule
`default_nettype wire

@@ rtl/rot3d_out.sv @@
`default_nettype none
module rot3d_out #(
   parameter int COORD_WIDTH = 32,
   parameter int TRIG_FRAC   = 30,
   parameter int PROD_W      = 66
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  rot3d_pkg::axis_type              in_func,
   input  logic [3*COORD_WIDTH-1:0]         in_vertex,
   input  logic signed [PROD_W-1:0]         in_ac,
   input  logic signed [PROD_W-1:0]         in_bs,
   input  logic signed [PROD_W-1:0]         in_as,
   input  logic signed [PROD_W-1:0]         in_bc,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [3*COORD_WIDTH-1:0]         out_vertex
);
   import rot3d_pkg::*;

   localparam int SUM_W = PROD_W + 1;

   logic                          valid_ff;
   logic [3*COORD_WIDTH-1:0]      vertex_ff, vertex_in;
   logic signed [SUM_W-1:0]       sum_a, sum_b, half_a, half_b;
   logic signed [SUM_W-1:0]       rnd_a, rnd_b;
   logic [COORD_WIDTH-1:0]        ra, rb;
   logic [COORD_WIDTH-1:0]        nx, ny, nz;

   function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-COORD_WIDTH:0] upper;
      logic [COORD_WIDTH-1:0]     r;
      upper = v[SUM_W-1:COORD_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         r = v[COORD_WIDTH-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   assign sum_a  = $signed({in_ac[PROD_W-1], in_ac}) - $signed({in_bs[PROD_W-1], in_bs});
   assign sum_b  = $signed({in_as[PROD_W-1], in_as}) + $signed({in_bc[PROD_W-1], in_bc});
   // round half up at the coordinate scale
   assign half_a = (sum_a >>> (TRIG_FRAC - 1)) + 1;
   assign half_b = (sum_b >>> (TRIG_FRAC - 1)) + 1;
   assign rnd_a  = half_a >>> 1;
   assign rnd_b  = half_b >>> 1;
   assign ra     = sat(rnd_a);
   assign rb     = sat(rnd_b);

   always_comb begin
      nx = in_vertex[COORD_WIDTH-1:0];
      ny = in_vertex[2*COORD_WIDTH-1:COORD_WIDTH];
      nz = in_vertex[3*COORD_WIDTH-1:2*COORD_WIDTH];
      case (in_func)
         AXIS_X: begin
            ny = ra;
            nz = rb;
         end
         AXIS_Y: begin
            nz = ra;
            nx = rb;
         end
         AXIS_Z: begin
            nx = ra;
            ny = rb;
         end
         default: begin
         end
      endcase
      vertex_in = {nz, ny, nx};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         vertex_ff <= vertex_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_vertex = vertex_ff;

endmodule
`default_nettype wire

@@ rtl/axis_rotation_3d_top.sv @@
// vertex rotation about a principal axis
// req channel: one vertex per transaction; tuser carries the axis code
// (x, y or z; code 3 passes the vertex through), tdata the coordinates and
// the binary angle. rsp channel: the rotated vertex, one transaction per
// request transaction, in order.
// pipeline: NUM_CELLS + 3 register stages, NUM_CELLS being TRIG_STAGES capped
// at 24: one per cordic cell, then quadrant mapping, the product stage and
// the rounding/saturation output register.
// throughput: one vertex per cycle while rsp_tready is high, set by the row
// of cordic cells, each of which takes a new angle every cycle.
// reset clears every stage valid; the pipeline is empty after reset and
// req_tready is high.
// when rsp_tready is low the output register holds its transaction; earlier
// stages keep filling, so empty slots close up, and req_tready drops only
// once all NUM_CELLS + 3 stages hold a vertex.
`default_nettype none
module axis_rotation_3d_top #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16,
   parameter int TRIG_STAGES = 16
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_tvalid,
   output logic                                               req_tready,
   // x_in, y_in, z_in, angle, zero pad
   input  logic [((3*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   // func
   input  logic [1:0]                                         req_tuser,
   output logic                                               rsp_tvalid,
   input  logic                                               rsp_tready,
   // x_out, y_out, z_out, zero pad
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]                 rsp_tdata
);
   import rot3d_pkg::*;

   `include "axis_rotation_3d_top_macros.svh"

   localparam int NUM_CELLS  = (TRIG_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STAGES;
   localparam int TRIG_FRAC  = ((62 - COORD_WIDTH) < CORDIC_FRAC) ?
                               (62 - COORD_WIDTH) : CORDIC_FRAC;
   localparam int TRIG_W     = TRIG_FRAC + 4;
   localparam int PROD_W     = COORD_WIDTH + TRIG_W;
   localparam int RSP_DATA_W = ((3*COORD_WIDTH+7)/8)*8;

   logic [ANGLE_WIDTH-1:0]  angle;
   logic [ANGLE_FULL_W-1:0] angle_full, angle_bias, resid;
   quad_type                quad;

   logic [NUM_CELLS:0]         cell_valid;
   logic [NUM_CELLS:0]         cell_ready;
   meta_type                   cell_meta   [0:NUM_CELLS];
   logic [3*COORD_WIDTH-1:0]   cell_vertex [0:NUM_CELLS];
   logic signed [CORDIC_W-1:0] cell_cx     [0:NUM_CELLS];
   logic signed [CORDIC_W-1:0] cell_cy     [0:NUM_CELLS];
   logic signed [RESID_W-1:0]  cell_cz     [0:NUM_CELLS];

   logic                          map_valid, map_ready;
   axis_type                      map_func;
   logic [3*COORD_WIDTH-1:0]      map_vertex;
   logic signed [COORD_WIDTH-1:0] map_a, map_b;
   logic signed [TRIG_W-1:0]      map_c, map_s;

   logic                          mult_valid, mult_ready;
   axis_type                      mult_func;
   logic [3*COORD_WIDTH-1:0]      mult_vertex;
   logic signed [PROD_W-1:0]      mult_ac, mult_bs, mult_as, mult_bc;

   logic                          out_ready_w;
   logic [3*COORD_WIDTH-1:0]      out_vertex;

   // quadrant split: residual angle lies in [-1/8, 1/8) turn
   assign angle      = req_tdata[3*COORD_WIDTH+ANGLE_WIDTH-1:3*COORD_WIDTH];
   assign angle_full = {angle, {(ANGLE_FULL_W-ANGLE_WIDTH){1'b0}}};
   assign angle_bias = angle_full + EIGHTH_TURN;
   assign quad       = quad_type'(angle_bias[ANGLE_FULL_W-1:ANGLE_FULL_W-2]);
   assign resid      = angle_full - {angle_bias[ANGLE_FULL_W-1:ANGLE_FULL_W-2],
                                     {(ANGLE_FULL_W-2){1'b0}}};

   assign cell_valid[0]  = req_tvalid;
   assign req_tready     = cell_ready[0];
   assign cell_meta[0]   = '{func: axis_type'(req_tuser), quad: quad};
   assign cell_vertex[0] = req_tdata[3*COORD_WIDTH-1:0];
   assign cell_cx[0]     = CORDIC_K;
   assign cell_cy[0]     = '0;
   assign cell_cz[0]     = $signed({resid[ANGLE_FULL_W-1], resid});

   generate
      for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
         rot3d_cordic_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .SHIFT       (k)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (cell_valid[k]),
            .in_ready   (cell_ready[k]),
            .in_meta    (cell_meta[k]),
            .in_vertex  (cell_vertex[k]),
            .in_cx      (cell_cx[k]),
            .in_cy      (cell_cy[k]),
            .in_cz      (cell_cz[k]),
            .out_valid  (cell_valid[k+1]),
            .out_ready  (cell_ready[k+1]),
            .out_meta   (cell_meta[k+1]),
            .out_vertex (cell_vertex[k+1]),
            .out_cx     (cell_cx[k+1]),
            .out_cy     (cell_cy[k+1]),
            .out_cz     (cell_cz[k+1])
         );
      end
   endgenerate

   assign cell_ready[NUM_CELLS] = map_ready;

   rot3d_trig_map #(
      .COORD_WIDTH (COORD_WIDTH),
      .TRIG_FRAC   (TRIG_FRAC),
      .TRIG_W      (TRIG_W)
   ) u_trig_map (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cell_valid[NUM_CELLS]),
      .in_ready   (map_ready),
      .in_meta    (cell_meta[NUM_CELLS]),
      .in_vertex  (cell_vertex[NUM_CELLS]),
      .in_cx      (cell_cx[NUM_CELLS]),
      .in_cy      (cell_cy[NUM_CELLS]),
      .out_valid  (map_valid),
      .out_ready  (mult_ready),
      .out_func   (map_func),
      .out_vertex (map_vertex),
      .out_a      (map_a),
      .out_b      (map_b),
      .out_c      (map_c),
      .out_s      (map_s)
   );

   rot3d_mult #(
      .COORD_WIDTH (COORD_WIDTH),
      .TRIG_W      (TRIG_W),
      .PROD_W      (PROD_W)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (map_valid),
      .in_ready   (mult_ready),
      .in_func    (map_func),
      .in_vertex  (map_vertex),
      .in_a       (map_a),
      .in_b       (map_b),
      .in_c       (map_c),
      .in_s       (map_s),
      .out_valid  (mult_valid),
      .out_ready  (out_ready_w),
      .out_func   (mult_func),
      .out_vertex (mult_vertex),
      .out_ac     (mult_ac),
      .out_bs     (mult_bs),
      .out_as     (mult_as),
      .out_bc     (mult_bc)
   );

   rot3d_out #(
      .COORD_WIDTH (COORD_WIDTH),
      .TRIG_FRAC   (TRIG_FRAC),
      .PROD_W      (PROD_W)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mult_valid),
      .in_ready   (out_ready_w),
      .in_func    (mult_func),
      .in_vertex  (mult_vertex),
      .in_ac      (mult_ac),
      .in_bs      (mult_bs),
      .in_as      (mult_as),
      .in_bc      (mult_bc),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_vertex (out_vertex)
   );

   assign rsp_tdata = RSP_DATA_W'(out_vertex);

   `ROT3D_ASSERT_ALWAYS(a_reset_empties, reset |=> (!rsp_tvalid && !cell_valid[1]))
   `ROT3D_ASSERT(a_stall_only_when_full, !req_tready |-> (&cell_valid[NUM_CELLS:1] && map_valid && mult_valid && rsp_tvalid && !rsp_tready))
   `ROT3D_ASSERT(a_rsp_from_products, $rose(rsp_tvalid) |-> $past(mult_valid))

endmodule
`default_nettype wire
